>>> sv/clc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the card number check block.
package clc_pkg;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned COUNT_W  = 5;
	localparam int unsigned PREFIX_W = 14;
	localparam int unsigned SUM_W    = 4;
	localparam int unsigned CLASS_W  = 3;

	localparam logic [COUNT_W-1:0] DIGIT_SAT  = 5'd20;
	localparam logic [COUNT_W-1:0] PREFIX_LEN = 5'd4;
	localparam logic [COUNT_W-1:0] LEN_MIN    = 5'd12;
	localparam logic [COUNT_W-1:0] LEN_MAX    = 5'd19;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_NINE = 8'd57;

	// Network class codes
	localparam logic [CLASS_W-1:0] CLASS_A      = 3'd0;
	localparam logic [CLASS_W-1:0] CLASS_B      = 3'd1;
	localparam logic [CLASS_W-1:0] CLASS_C      = 3'd2;
	localparam logic [CLASS_W-1:0] CLASS_D      = 3'd3;
	localparam logic [CLASS_W-1:0] CLASS_PREFIX = 3'd4;
	localparam logic [CLASS_W-1:0] CLASS_OTHER  = 3'd5;

	// Classified character, carried from front to back
	typedef struct packed {
		logic               is_digit;
		logic [DIGIT_W-1:0] digit;
		logic               is_last;
	} clc_item_t;

	// One result transaction
	typedef struct packed {
		logic               valid_res;
		logic [CLASS_W-1:0] card_class;
		logic [COUNT_W-1:0] digit_length;
	} clc_result_t;

	// Luhn doubling of one digit
	function automatic logic [SUM_W-1:0] luhn_double(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W:0] v;
		v = {d, 1'b0};
		if (v > 5'd9) begin
			v = v - 5'd9;
		end
		return v[SUM_W-1:0];
	endfunction

	// Add two values below ten, mod ten
	function automatic logic [SUM_W-1:0] add_mod10(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 5'd10) begin
			s = s - 5'd10;
		end
		return s[SUM_W-1:0];
	endfunction

	// Network class from prefix and length, first match wins
	function automatic logic [CLASS_W-1:0] pick_class(input logic [PREFIX_W-1:0] p,
		input logic [COUNT_W-1:0] len);
		logic [CLASS_W-1:0] c;
		if ((len == 5'd13 || len == 5'd16) && (p inside {[14'd4000:14'd4999]})) begin
			c = CLASS_A;
		end else if (len == 5'd16 && ((p inside {[14'd5100:14'd5599]}) ||
			(p inside {[14'd2221:14'd2720]}))) begin
			c = CLASS_B;
		end else if (len == 5'd15 && (p inside {[14'd3400:14'd3499], [14'd3700:14'd3799]})) begin
			c = CLASS_C;
		end else if ((len inside {[5'd14:5'd19]}) && (p inside {[14'd3600:14'd3699]})) begin
			c = CLASS_D;
		end else if (p inside {14'd5018, 14'd5020, 14'd5038, 14'd5893, 14'd6304,
			14'd6759, 14'd6761, 14'd6762, 14'd6763}) begin
			c = CLASS_PREFIX;
		end else begin
			c = CLASS_OTHER;
		end
		return c;
	endfunction

endpackage

>>> sv/clc_fifo.sv
`timescale 1ns / 1ps
// Small register-based FIFO queue used between the block's stages.
module clc_fifo #(
	parameter int unsigned WIDTH = 6,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Store the incoming transaction
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/clc_front.sv
`timescale 1ns / 1ps
// Front end: accepts character bytes, classifies them and queues them for the back end.
module clc_front #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          char_byte,
	input  logic                is_last,
	input  logic                take,
	output clc_pkg::clc_item_t  item,
	output logic                item_empty
);

	clc_pkg::clc_item_t cls;
	logic [7:0]         offs;

	// Classify the byte: digit flag and value
	always_comb begin
		offs         = char_byte - clc_pkg::CHAR_ZERO;
		cls.is_digit = (char_byte >= clc_pkg::CHAR_ZERO) && (char_byte <= clc_pkg::CHAR_NINE);
		cls.digit    = offs[clc_pkg::DIGIT_W-1:0];
		cls.is_last  = is_last;
	end

	// Hold classified transactions until the back end takes them
	clc_fifo #(
		.WIDTH ($bits(clc_pkg::clc_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cls),
		.full    (full),
		.rd_en   (take),
		.rd_data (item),
		.empty   (item_empty)
	);

endmodule

>>> sv/clc_back.sv
`timescale 1ns / 1ps
// Back end: Luhn sums, digit count and prefix; forms one result per number.
module clc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  clc_pkg::clc_item_t   item,
	input  logic                 item_empty,
	output logic                 take,
	input  logic                 res_full,
	output logic                 res_push,
	output clc_pkg::clc_result_t res_data
);

	logic [clc_pkg::COUNT_W-1:0]  digit_count_q;
	logic [clc_pkg::PREFIX_W-1:0] prefix_value_q;
	logic [clc_pkg::SUM_W-1:0]    sum_even_q;
	logic [clc_pkg::SUM_W-1:0]    sum_odd_q;

	logic [clc_pkg::COUNT_W-1:0]  count_n;
	logic [clc_pkg::PREFIX_W-1:0] prefix_n;
	logic [clc_pkg::SUM_W-1:0]    even_n;
	logic [clc_pkg::SUM_W-1:0]    odd_n;
	logic [clc_pkg::SUM_W-1:0]    dbl;
	logic [clc_pkg::SUM_W-1:0]    digit_ext;
	logic [clc_pkg::SUM_W-1:0]    sel_sum;
	logic                         ok;

	assign take     = !item_empty && !res_full;
	assign res_push = take && item.is_last;

	// Fold one digit into the running state
	always_comb begin
		digit_ext = item.digit;
		dbl       = clc_pkg::luhn_double(item.digit);
		count_n   = digit_count_q;
		prefix_n  = prefix_value_q;
		even_n    = sum_even_q;
		odd_n     = sum_odd_q;
		if (item.is_digit) begin
			if (!digit_count_q[0]) begin
				even_n = clc_pkg::add_mod10(sum_even_q, dbl);
				odd_n  = clc_pkg::add_mod10(sum_odd_q, digit_ext);
			end else begin
				even_n = clc_pkg::add_mod10(sum_even_q, digit_ext);
				odd_n  = clc_pkg::add_mod10(sum_odd_q, dbl);
			end
			if (digit_count_q < clc_pkg::PREFIX_LEN) begin
				prefix_n = (prefix_value_q << 3) + (prefix_value_q << 1)
					+ clc_pkg::PREFIX_W'(item.digit);
			end
			if (digit_count_q < clc_pkg::DIGIT_SAT) begin
				count_n = digit_count_q + 1'b1;
			end
		end
	end

	// Form the result: check digit is never doubled, so length parity picks the sum
	always_comb begin
		sel_sum               = count_n[0] ? odd_n : even_n;
		ok                    = (count_n >= clc_pkg::LEN_MIN) && (count_n <= clc_pkg::LEN_MAX)
			&& (sel_sum == '0);
		res_data.valid_res    = ok;
		res_data.card_class   = ok ? clc_pkg::pick_class(prefix_n, count_n)
			: clc_pkg::CLASS_OTHER;
		res_data.digit_length = count_n;
	end

	// Update state; clear it once a number is finished
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q  <= '0;
			prefix_value_q <= '0;
			sum_even_q     <= '0;
			sum_odd_q      <= '0;
		end else if (take) begin
			if (item.is_last) begin
				digit_count_q  <= '0;
				prefix_value_q <= '0;
				sum_even_q     <= '0;
				sum_odd_q      <= '0;
			end else begin
				digit_count_q  <= count_n;
				prefix_value_q <= prefix_n;
				sum_even_q     <= even_n;
				sum_odd_q      <= odd_n;
			end
		end
	end

endmodule

>>> sv/card_number_luhn_check_top.sv
`timescale 1ns / 1ps
// Top level of the card number Luhn check block.
//
// Feed the card number one character byte per cycle through push/full; bytes other
// than ASCII '0'..'9' are skipped, and the byte with is_last set closes the number.
// The block sustains one byte per clock while the result queue has room: the back end
// folds each queued byte into its Luhn sums, digit count and prefix combinationally and
// registers the new state as it takes the byte. A result enters the output queue as
// the back end takes its last byte from the front queue. QUEUE_DEPTH-entry queues
// between front and back and before the result ports let either side stall alone.
// valid_res flags lengths 12..19 with a Luhn sum of zero mod ten; card_class gives
// the network class only for valid numbers and reads as other otherwise.
module card_number_luhn_check_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_byte,
	input  logic       is_last,
	input  logic       pop,
	output logic       empty,
	output logic       valid_res,
	output logic [2:0] card_class,
	output logic [4:0] digit_length
);

	clc_pkg::clc_item_t   item;
	logic                 item_empty;
	logic                 take;
	logic                 res_full;
	logic                 res_push;
	clc_pkg::clc_result_t res_in;
	clc_pkg::clc_result_t res_out;

	clc_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.char_byte  (char_byte),
		.is_last    (is_last),
		.take       (take),
		.item       (item),
		.item_empty (item_empty)
	);

	clc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_empty (item_empty),
		.take       (take),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_data   (res_in)
	);

	// Queue results until the consumer pops them
	clc_fifo #(
		.WIDTH ($bits(clc_pkg::clc_result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign valid_res    = res_out.valid_res;
	assign card_class   = res_out.card_class;
	assign digit_length = res_out.digit_length;

endmodule

>>> sv/clc_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the card number check block, with the bind to the top level.
module clc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic [7:0] char_byte,
	input logic       is_last,
	input logic       pop,
	input logic       empty,
	input logic       valid_res,
	input logic [2:0] card_class,
	input logic [4:0] digit_length
);

	// Valid results only for lengths 12 to 19
	a_valid_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && valid_res) |-> (digit_length >= 5'd12 && digit_length <= 5'd19))
		else $error("valid result with out-of-range length");

	// Invalid results carry the other class
	a_invalid_class: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !valid_res) |-> (card_class == clc_pkg::CLASS_OTHER))
		else $error("invalid result with a network class");

	// Length saturates at 20
	a_len_sat: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (digit_length <= clc_pkg::DIGIT_SAT))
		else $error("digit length beyond saturation");

	// A waiting result holds until popped
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(valid_res) && $stable(card_class)
			&& $stable(digit_length)))
		else $error("waiting result changed before pop");

endmodule

bind card_number_luhn_check_top clc_checker u_clc_checker (.*);
